### rtl/core/fdfd_pkg.sv
// ----------------------------------------------------------------------------
// Flood dedup forwarding decision package
// Shared types, operation and action codes and default sizes of the block.
// ----------------------------------------------------------------------------
package fdfd_pkg;

    localparam int DEF_RING_DEPTH    = 1024;
    localparam int DEF_ROUTE_ENTRIES = 16;

    localparam int ID_W     = 16;
    localparam int IP_W     = 32;
    localparam int ETYPE_W  = 16;
    localparam int OP_W     = 2;
    localparam int ACT_W    = 3;
    localparam int IDX_W    = 4;
    localparam int RCOUNT_W = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [ETYPE_W-1:0] ETHER_IP = 16'h0800;

    localparam logic [OP_W-1:0] OP_RECEIVE     = 2'd0;
    localparam logic [OP_W-1:0] OP_ORIGINATE   = 2'd1;
    localparam logic [OP_W-1:0] OP_ROUTE_WRITE = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED      = 2'd3;

    localparam logic [ACT_W-1:0] ACT_DUPLICATE     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_NOT_IP        = 3'd1;
    localparam logic [ACT_W-1:0] ACT_DELIVER       = 3'd2;
    localparam logic [ACT_W-1:0] ACT_FORWARD       = 3'd3;
    localparam logic [ACT_W-1:0] ACT_NO_ROUTE      = 3'd4;
    localparam logic [ACT_W-1:0] ACT_FOREIGN_SRC   = 3'd5;
    localparam logic [ACT_W-1:0] ACT_ROUTE_WRITTEN = 3'd6;
    localparam logic [ACT_W-1:0] ACT_SEND_ORIG     = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP      = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROUTE_COUNT = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_LOCAL_SCAN,
        S_CLASSIFY,
        S_FWD_SCAN,
        S_ROUTE_SCAN
    } fdfd_state_t;

    typedef struct packed {
        logic            put;
        logic [ID_W-1:0] id;
    } ring_req_t;

endpackage

### rtl/core/fdfd_ring.sv
// ----------------------------------------------------------------------------
// Frame id ring
// Circular id store with a write position and a fill count; one read port
// with registered data for the sequential membership scan.
// ----------------------------------------------------------------------------
module fdfd_ring #(
    parameter int DEPTH = fdfd_pkg::DEF_RING_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  fdfd_pkg::ring_req_t               req,
    input  logic                              rd_en,
    input  logic [$clog2(DEPTH)-1:0]          rd_addr,
    output logic [fdfd_pkg::ID_W-1:0]         rd_data,
    output logic [$clog2(DEPTH+1)-1:0]        fill
);
    import fdfd_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int FW = $clog2(DEPTH + 1);

    logic [ID_W-1:0] ids_mem [DEPTH];
    logic [ID_W-1:0] rd_data_reg;
    logic [AW-1:0]   pos_reg;
    logic [AW-1:0]   pos_next;
    logic [FW-1:0]   fill_reg;
    logic [FW-1:0]   fill_next;

    always_comb
    begin
        pos_next  = pos_reg;
        fill_next = fill_reg;
        if (req.put)
        begin
            if (pos_reg == AW'(DEPTH - 1))
            begin
                pos_next = '0;
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
            if (fill_reg != FW'(DEPTH))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            fill_reg <= '0;
        end
        else
        begin
            pos_reg  <= pos_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.put)
        begin
            ids_mem[pos_reg] <= req.id;
        end
        if (rd_en)
        begin
            rd_data_reg <= ids_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign fill    = fill_reg;

endmodule

### rtl/core/flood_dedup_forward_decision_top.sv
// ----------------------------------------------------------------------------
// Flood dedup forwarding decision
// Per-frame drop, deliver or forward decision with duplicate filtering over
// two id rings and a first-match route table search.
//
// Channel   Direction  Handshake              Transaction
// command   in         start & !busy          operation and frame fields
// result    out        done (one cycle)       action, next hop, stamped id
// config    in         cfg_valid & cfg_ready  register index and data
//
// Scan time is set by the single comparator stepping one ring or route entry
// per cycle through each memory's read port. A receive item scans at most
// both rings and the route table, an originate item at most the route table,
// and a route write none. Reset needs no clearing pass, as the rings use fill
// counts. Results cannot be held off; busy stays high until done, except that
// the unused operation code returns to idle with no done.
// ----------------------------------------------------------------------------
module flood_dedup_forward_decision_top #(
    parameter int RING_DEPTH    = fdfd_pkg::DEF_RING_DEPTH,
    parameter int ROUTE_ENTRIES = fdfd_pkg::DEF_ROUTE_ENTRIES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [fdfd_pkg::OP_W-1:0]         operation,
    input  logic [fdfd_pkg::ID_W-1:0]         flood_id,
    input  logic [fdfd_pkg::ETYPE_W-1:0]      ether_type,
    input  logic [fdfd_pkg::IP_W-1:0]         src_ip,
    input  logic [fdfd_pkg::IP_W-1:0]         dst_ip,
    input  logic [fdfd_pkg::IDX_W-1:0]        entry_index,
    input  logic [fdfd_pkg::IP_W-1:0]         entry_dest,
    input  logic [fdfd_pkg::IP_W-1:0]         entry_next_hop,
    output logic                              done,
    output logic [fdfd_pkg::ACT_W-1:0]        action,
    output logic [fdfd_pkg::IP_W-1:0]         next_hop_ip,
    output logic [fdfd_pkg::ID_W-1:0]         stamped_id,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fdfd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fdfd_pkg::IP_W-1:0]         cfg_data
);
    import fdfd_pkg::*;

    localparam int RING_AW  = $clog2(RING_DEPTH);
    localparam int RING_FW  = $clog2(RING_DEPTH + 1);
    localparam int ROUTE_AW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
    localparam int ROUTE_FW = $clog2(ROUTE_ENTRIES + 1);
    localparam int CNT_W    = (RING_FW > ROUTE_FW) ? RING_FW : ROUTE_FW;

    fdfd_state_t state_reg;
    fdfd_state_t state_next;

    logic [IP_W-1:0]     own_ip_reg;
    logic [RCOUNT_W-1:0] route_count_reg;

    logic [OP_W-1:0]     op_reg;
    logic [ID_W-1:0]     fid_reg;
    logic [ETYPE_W-1:0]  etype_reg;
    logic [IP_W-1:0]     src_reg;
    logic [IP_W-1:0]     dst_reg;
    logic [IDX_W-1:0]    idx_reg;
    logic [IP_W-1:0]     edest_reg;
    logic [IP_W-1:0]     ehop_reg;
    logic [ID_W-1:0]     id_counter_reg;
    logic [ID_W-1:0]     stamp_reg;

    logic [CNT_W-1:0]    cnt_reg;
    logic                pend_reg;

    logic                done_reg;
    logic [ACT_W-1:0]    action_reg;
    logic [IP_W-1:0]     hop_reg;
    logic [ID_W-1:0]     stamped_reg;

    logic [2*IP_W-1:0]   route_mem [ROUTE_ENTRIES];
    logic [2*IP_W-1:0]   route_rd_reg;
    logic [IP_W-1:0]     route_rd_dest;
    logic [IP_W-1:0]     route_rd_hop;

    ring_req_t           local_req;
    ring_req_t           fwd_req;
    logic [ID_W-1:0]     local_rd;
    logic [ID_W-1:0]     fwd_rd;
    logic [RING_FW-1:0]  local_fill;
    logic [RING_FW-1:0]  fwd_fill;
    logic                local_rd_en;
    logic                fwd_rd_en;
    logic                route_rd_en;

    logic [IP_W-1:0]     cmp_a;
    logic [IP_W-1:0]     cmp_b;
    logic                cmp_eq;

    logic                accept;
    logic                in_scan;
    logic [CNT_W-1:0]    route_limit;
    logic [CNT_W-1:0]    scan_limit;
    logic                issue;
    logic                hit_now;
    logic                scan_miss;
    logic                idx_in_range;

    logic                local_put;
    logic                fwd_put;
    logic                route_wr;
    logic                id_inc;
    logic                res_set;
    logic [ACT_W-1:0]    res_action;
    logic [IP_W-1:0]     res_hop;
    logic [ID_W-1:0]     res_stamp;

    assign accept    = start && (state_reg == S_IDLE);
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    assign route_rd_dest = route_rd_reg[2*IP_W-1:IP_W];
    assign route_rd_hop  = route_rd_reg[IP_W-1:0];
    assign idx_in_range  = (32'(idx_reg) < 32'(ROUTE_ENTRIES));

    assign route_limit = (32'(route_count_reg) > 32'(ROUTE_ENTRIES)) ?
                         CNT_W'(ROUTE_ENTRIES) : CNT_W'(route_count_reg);

    assign in_scan = (state_reg == S_LOCAL_SCAN) || (state_reg == S_FWD_SCAN) ||
                     (state_reg == S_ROUTE_SCAN);

    always_comb
    begin
        unique case (state_reg)
            S_LOCAL_SCAN:
            begin
                scan_limit = CNT_W'(local_fill);
            end
            S_FWD_SCAN:
            begin
                scan_limit = CNT_W'(fwd_fill);
            end
            default:
            begin
                scan_limit = route_limit;
            end
        endcase
    end

    // The one comparator of the block, steered by the sequencer.
    always_comb
    begin
        unique case (state_reg)
            S_DISPATCH:
            begin
                cmp_a = src_reg;
                cmp_b = own_ip_reg;
            end
            S_CLASSIFY:
            begin
                cmp_a = dst_reg;
                cmp_b = own_ip_reg;
            end
            S_LOCAL_SCAN:
            begin
                cmp_a = IP_W'(local_rd);
                cmp_b = IP_W'(fid_reg);
            end
            S_FWD_SCAN:
            begin
                cmp_a = IP_W'(fwd_rd);
                cmp_b = IP_W'(fid_reg);
            end
            S_ROUTE_SCAN:
            begin
                cmp_a = route_rd_dest;
                cmp_b = dst_reg;
            end
            default:
            begin
                cmp_a = '0;
                cmp_b = '0;
            end
        endcase
    end

    assign cmp_eq    = (cmp_a == cmp_b);
    assign hit_now   = in_scan && pend_reg && cmp_eq;
    assign issue     = in_scan && (cnt_reg < scan_limit) && !hit_now;
    assign scan_miss = in_scan && (cnt_reg >= scan_limit) && !hit_now;

    assign local_rd_en = issue && (state_reg == S_LOCAL_SCAN);
    assign fwd_rd_en   = issue && (state_reg == S_FWD_SCAN);
    assign route_rd_en = issue && (state_reg == S_ROUTE_SCAN);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (op_reg)
                    OP_RECEIVE:
                    begin
                        state_next = S_LOCAL_SCAN;
                    end
                    OP_ORIGINATE:
                    begin
                        state_next = cmp_eq ? S_ROUTE_SCAN : S_IDLE;
                    end
                    OP_ROUTE_WRITE, OP_UNUSED:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_LOCAL_SCAN:
            begin
                if (hit_now)
                begin
                    state_next = S_IDLE;
                end
                else if (scan_miss)
                begin
                    state_next = S_CLASSIFY;
                end
            end
            S_CLASSIFY:
            begin
                if ((etype_reg != ETHER_IP) || cmp_eq)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_FWD_SCAN;
                end
            end
            S_FWD_SCAN:
            begin
                if (hit_now)
                begin
                    state_next = S_IDLE;
                end
                else if (scan_miss)
                begin
                    state_next = S_ROUTE_SCAN;
                end
            end
            S_ROUTE_SCAN:
            begin
                if (hit_now || scan_miss)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        local_put  = 1'b0;
        fwd_put    = 1'b0;
        route_wr   = 1'b0;
        id_inc     = 1'b0;
        res_set    = 1'b0;
        res_action = ACT_DUPLICATE;
        res_hop    = '0;
        res_stamp  = (op_reg == OP_ORIGINATE) ? stamp_reg : '0;
        unique case (state_reg)
            S_DISPATCH:
            begin
                unique case (op_reg)
                    OP_ORIGINATE:
                    begin
                        id_inc    = 1'b1;
                        res_stamp = id_counter_reg;
                        if (cmp_eq)
                        begin
                            fwd_put = 1'b1;
                        end
                        else
                        begin
                            res_set    = 1'b1;
                            res_action = ACT_FOREIGN_SRC;
                        end
                    end
                    OP_ROUTE_WRITE:
                    begin
                        route_wr   = idx_in_range;
                        res_set    = 1'b1;
                        res_action = ACT_ROUTE_WRITTEN;
                    end
                    OP_RECEIVE, OP_UNUSED:
                    begin
                    end
                endcase
            end
            S_LOCAL_SCAN:
            begin
                if (hit_now)
                begin
                    res_set    = 1'b1;
                    res_action = ACT_DUPLICATE;
                end
            end
            S_CLASSIFY:
            begin
                if (etype_reg != ETHER_IP)
                begin
                    res_set    = 1'b1;
                    res_action = ACT_NOT_IP;
                end
                else if (cmp_eq)
                begin
                    local_put  = 1'b1;
                    res_set    = 1'b1;
                    res_action = ACT_DELIVER;
                end
            end
            S_FWD_SCAN:
            begin
                if (hit_now)
                begin
                    res_set    = 1'b1;
                    res_action = ACT_DUPLICATE;
                end
                else if (scan_miss)
                begin
                    fwd_put = 1'b1;
                end
            end
            S_ROUTE_SCAN:
            begin
                if (hit_now && (route_rd_hop != '0))
                begin
                    res_set    = 1'b1;
                    res_hop    = route_rd_hop;
                    res_action = (op_reg == OP_ORIGINATE) ? ACT_SEND_ORIG : ACT_FORWARD;
                end
                else if (hit_now || scan_miss)
                begin
                    res_set    = 1'b1;
                    res_action = ACT_NO_ROUTE;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign local_req.put = local_put;
    assign local_req.id  = fid_reg;
    assign fwd_req.put   = fwd_put;
    assign fwd_req.id    = (op_reg == OP_ORIGINATE) ? id_counter_reg : fid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            own_ip_reg      <= '0;
            route_count_reg <= '0;
            id_counter_reg  <= ID_W'(1);
            cnt_reg         <= '0;
            pend_reg        <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= res_set;
            pend_reg  <= issue;
            if (state_next != state_reg)
            begin
                cnt_reg <= '0;
            end
            else if (issue)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (id_inc)
            begin
                id_counter_reg <= id_counter_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_OWN_IP:
                    begin
                        own_ip_reg <= cfg_data;
                    end
                    CFG_ROUTE_COUNT:
                    begin
                        route_count_reg <= cfg_data[RCOUNT_W-1:0];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= operation;
            fid_reg   <= flood_id;
            etype_reg <= ether_type;
            src_reg   <= src_ip;
            dst_reg   <= dst_ip;
            idx_reg   <= entry_index;
            edest_reg <= entry_dest;
            ehop_reg  <= entry_next_hop;
        end
        if ((state_reg == S_DISPATCH) && (op_reg == OP_ORIGINATE))
        begin
            stamp_reg <= id_counter_reg;
        end
        if (res_set)
        begin
            action_reg  <= res_action;
            hop_reg     <= res_hop;
            stamped_reg <= res_stamp;
        end
    end

    always_ff @(posedge clk)
    begin
        if (route_wr)
        begin
            route_mem[ROUTE_AW'(idx_reg)] <= {edest_reg, ehop_reg};
        end
        if (route_rd_en)
        begin
            route_rd_reg <= route_mem[cnt_reg[ROUTE_AW-1:0]];
        end
    end

    fdfd_ring #(
        .DEPTH (RING_DEPTH)
    ) u_local_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (local_req),
        .rd_en   (local_rd_en),
        .rd_addr (cnt_reg[RING_AW-1:0]),
        .rd_data (local_rd),
        .fill    (local_fill)
    );

    fdfd_ring #(
        .DEPTH (RING_DEPTH)
    ) u_fwd_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (fwd_req),
        .rd_en   (fwd_rd_en),
        .rd_addr (cnt_reg[RING_AW-1:0]),
        .rd_data (fwd_rd),
        .fill    (fwd_fill)
    );

    assign done        = done_reg;
    assign action      = action_reg;
    assign next_hop_ip = hop_reg;
    assign stamped_id  = stamped_reg;

endmodule
